@@ src/pvd_pkg.sv @@
// shared types, constants and the factorial table for the polynomial value and
// derivatives block; used by the channel interfaces and the top level
`default_nettype none

package pvd_pkg;

	localparam int DEGREE    = 7;
	localparam int FRAC_BITS = 16;
	localparam int NUM_REGS  = 8;
	localparam int DATA_W    = 32;
	localparam int ORDER_W   = 3;
	localparam int ADDR_W    = 5;
	localparam int IDX_W     = (DEGREE < 2) ? 1 : $clog2(DEGREE + 1);
	localparam int FACT_W    = 13;

	// round half up before the fractional shift, none for integer format
	localparam logic signed [63:0] RND = (64'sd1 <<< FRAC_BITS) >>> 1;
	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [ORDER_W-1:0]       order_t;

	function automatic logic [FACT_W-1:0] fact(input logic [ORDER_W-1:0] k);
		logic [FACT_W-1:0] f;
		case (k)
			3'd0:    f = 13'd1;
			3'd1:    f = 13'd1;
			3'd2:    f = 13'd2;
			3'd3:    f = 13'd6;
			3'd4:    f = 13'd24;
			3'd5:    f = 13'd120;
			3'd6:    f = 13'd720;
			3'd7:    f = 13'd5040;
			default: f = 13'd1;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

@@ src/pvd_point_if.sv @@
// channel interfaces: evaluation point in, value and derivative items out
// depends on pvd_pkg
`default_nettype none

interface pvd_point_if;
	logic          valid;
	logic          ready;
	pvd_pkg::word_t point;

	modport source (output valid, output point, input ready);
	modport sink (input valid, input point, output ready);
endinterface

interface pvd_result_if;
	logic            valid;
	logic            ready;
	pvd_pkg::order_t order;
	pvd_pkg::word_t  amount;
	logic            saturated;
	logic            last;

	modport source (output valid, output order, output amount, output saturated,
		output last, input ready);
	modport sink (input valid, input order, input amount, input saturated,
		input last, output ready);
endinterface

`default_nettype wire

@@ src/polynomial_value_and_derivatives.sv @@
// polynomial value and derivatives by repeated synthetic division, one shared
// 32x32 multiplier and one 64-bit add/clamp stage under a small sequencer.
// each of the DEGREE*(DEGREE+1)/2 division steps is a multiply then an add state,
// each of the DEGREE+1 scalings by k! likewise, its add state waiting for a free
// output slot; a new point is taken only in idle, once the last result is
// registered. reset clears the coefficients to zero and the sequencer.
`default_nettype none

module polynomial_value_and_derivatives (
	input  wire                               clk,
	input  wire                               arst_n,
	pvd_point_if.sink                         sample,
	pvd_result_if.source                      result,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [pvd_pkg::ADDR_W-1:0]        paddr,
	input  wire  [pvd_pkg::DATA_W-1:0]        pwdata,
	output logic [pvd_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_SMUL,
		ST_SADD
	} state_t;

	state_t state_q;

	pvd_pkg::word_t coef_q [pvd_pkg::NUM_REGS];
	pvd_pkg::word_t w_q [pvd_pkg::DEGREE + 1];
	logic           stk_q [pvd_pkg::DEGREE + 1];
	pvd_pkg::word_t x_q;
	pvd_pkg::word_t prev_q;
	logic           prev_stk_q;
	logic signed [63:0] prod_q;

	pvd_pkg::idx_t i_q, j_q, k_q;

	logic             res_valid_q;
	pvd_pkg::order_t  res_order_q;
	pvd_pkg::word_t   res_amount_q;
	logic             res_sat_q;
	logic             res_last_q;

	logic               wr_en;
	logic [pvd_pkg::ORDER_W-1:0] rd_idx;
	pvd_pkg::idx_t      rd_addr;
	pvd_pkg::word_t     rd_word;
	logic               rd_stk;
	pvd_pkg::word_t     mul_a, mul_b;
	logic signed [63:0] prod_d;
	logic signed [63:0] scaled;
	logic signed [63:0] sum;
	pvd_pkg::word_t     clamped;
	logic               clip;
	logic               slot_free;

	// configuration port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign prdata = coef_q[paddr[pvd_pkg::ADDR_W-1:2]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < pvd_pkg::NUM_REGS; r++) begin
				coef_q[r] <= '0;
			end
		end else if (wr_en) begin
			coef_q[paddr[pvd_pkg::ADDR_W-1:2]] <= pwdata;
		end
	end

	// shared datapath
	assign rd_addr = (state_q == ST_ADD) ? j_q : pvd_pkg::idx_t'(pvd_pkg::DEGREE) - k_q;
	assign rd_word = w_q[rd_addr];
	assign rd_stk  = stk_q[rd_addr];
	assign rd_idx  = pvd_pkg::ORDER_W'(k_q);

	assign mul_a  = (state_q == ST_MUL) ? prev_q : rd_word;
	assign mul_b  = (state_q == ST_MUL) ? x_q
		: pvd_pkg::word_t'(pvd_pkg::fact(rd_idx));
	assign prod_d = 64'(mul_a) * 64'(mul_b);

	// division step rounds and adds w[j]; scaling passes the exact product
	assign scaled = (state_q == ST_ADD) ? ((prod_q + pvd_pkg::RND) >>> pvd_pkg::FRAC_BITS)
		: prod_q;
	assign sum    = (state_q == ST_ADD) ? scaled + 64'(rd_word) : scaled;

	always_comb begin
		clip    = 1'b0;
		clamped = pvd_pkg::word_t'(sum);
		if (sum > pvd_pkg::SAT_MAX) begin
			clip    = 1'b1;
			clamped = pvd_pkg::word_t'(pvd_pkg::SAT_MAX);
		end else if (sum < pvd_pkg::SAT_MIN) begin
			clip    = 1'b1;
			clamped = pvd_pkg::word_t'(pvd_pkg::SAT_MIN);
		end
	end

	assign slot_free    = !res_valid_q || result.ready;
	assign sample.ready = (state_q == ST_IDLE);

	// working values and product, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && sample.valid) begin
			for (int r = 0; r <= pvd_pkg::DEGREE; r++) begin
				w_q[r]   <= coef_q[r];
				stk_q[r] <= 1'b0;
			end
			x_q        <= sample.point;
			prev_q     <= coef_q[0];
			prev_stk_q <= 1'b0;
		end
		if (state_q == ST_MUL || state_q == ST_SMUL) begin
			prod_q <= prod_d;
		end
		if (state_q == ST_ADD) begin
			w_q[j_q]   <= clamped;
			stk_q[j_q] <= rd_stk || prev_stk_q || clip;
			if (j_q == i_q) begin
				// next pass restarts from the leading coefficient
				prev_q     <= w_q[0];
				prev_stk_q <= stk_q[0];
			end else begin
				prev_q     <= clamped;
				prev_stk_q <= rd_stk || prev_stk_q || clip;
			end
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			res_valid_q  <= 1'b0;
			res_order_q  <= '0;
			res_amount_q <= '0;
			res_sat_q    <= 1'b0;
			res_last_q   <= 1'b0;
		end else begin
			if (state_q == ST_SADD && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						i_q     <= pvd_pkg::idx_t'(pvd_pkg::DEGREE);
						j_q     <= pvd_pkg::idx_t'(1);
						k_q     <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (j_q != i_q) begin
						j_q     <= j_q + pvd_pkg::idx_t'(1);
						state_q <= ST_MUL;
					end else if (i_q != pvd_pkg::idx_t'(1)) begin
						i_q     <= i_q - pvd_pkg::idx_t'(1);
						j_q     <= pvd_pkg::idx_t'(1);
						state_q <= ST_MUL;
					end else begin
						k_q     <= '0;
						state_q <= ST_SMUL;
					end
				end
				ST_SMUL: begin
					state_q <= ST_SADD;
				end
				ST_SADD: begin
					if (slot_free) begin
						res_order_q  <= rd_idx;
						res_amount_q <= clamped;
						res_sat_q    <= rd_stk || clip;
						res_last_q   <= (k_q == pvd_pkg::idx_t'(pvd_pkg::DEGREE));
						if (k_q == pvd_pkg::idx_t'(pvd_pkg::DEGREE)) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + pvd_pkg::idx_t'(1);
							state_q <= ST_SMUL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid     = res_valid_q;
	assign result.order     = res_order_q;
	assign result.amount    = res_amount_q;
	assign result.saturated = res_sat_q;
	assign result.last      = res_last_q;

endmodule

`default_nettype wire
